/* design/uod_pkg.sv */
`timescale 1ns / 1ps

package uod_pkg;

  localparam int DIST_BITS = 21;
  localparam int EXIT_BITS = 4;
  localparam int PHASE_BITS = 2;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS = 21;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LOW = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HIGH = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_TOLERANCE = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_SAMPLES = 4'd3;

  localparam logic [DIST_BITS-1:0] WINDOW_LOW_RESET = 21'd20000;
  localparam logic [DIST_BITS-1:0] WINDOW_HIGH_RESET = 21'd40000;
  localparam logic [DIST_BITS-1:0] MATCH_TOLERANCE_RESET = 21'd4000;
  localparam logic [EXIT_BITS-1:0] EXIT_SAMPLES_RESET = 4'd3;

  // Encoded phase as reported on the result channel.
  localparam logic [PHASE_BITS-1:0] PHASE_IDLE = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_CONFIRM = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_PRESENT = 2'd2;
  localparam logic [PHASE_BITS-1:0] PHASE_EXIT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONFIRM = 4'b0010,
    ST_PRESENT = 4'b0100,
    ST_EXIT    = 4'b1000
  } state_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] window_low;
    logic [DIST_BITS-1:0] window_high;
    logic [DIST_BITS-1:0] match_tolerance;
    logic [EXIT_BITS-1:0] exit_samples;
  } cfg_t;

  typedef struct packed {
    logic                 advance;
    logic                 result_ready;
  } flow_t;

endpackage

/* design/uod_sample_if.sv */
`timescale 1ns / 1ps

interface uod_sample_if #(
  parameter int ECHO_WIDTH_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic [ECHO_WIDTH_BITS-1:0] echo_width_us;
  logic                       echo_timeout;

  modport source (output valid, output echo_width_us, output echo_timeout, input ready);
  modport sink (input valid, input echo_width_us, input echo_timeout, output ready);
endinterface

/* design/uod_result_if.sv */
`timescale 1ns / 1ps

interface uod_result_if
  import uod_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [DIST_BITS-1:0]  distance_mcm;
  logic                  car_present;
  logic                  car_arrived;
  logic                  car_left;
  logic [PHASE_BITS-1:0] phase;

  modport source (output valid, output distance_mcm, output car_present,
                  output car_arrived, output car_left, output phase, input ready);
  modport sink (input valid, input distance_mcm, input car_present,
                input car_arrived, input car_left, input phase, output ready);
endinterface

/* design/uod_cfg_if.sv */
`timescale 1ns / 1ps

interface uod_cfg_if
  import uod_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/ultrasonic_occupancy_detector.sv */
`timescale 1ns / 1ps

// Channel   Role    Beat contents
// sample    sink    echo_width_us, echo_timeout
// result    source  distance_mcm, car_present, car_arrived, car_left, phase
// cfg       sink    index, data (always ready)
//
// A sample passes two registers: the input register at acceptance, then the
// distance and phase logic feeding the result register.
// One sample is accepted per cycle as long as the result side keeps up.
// A stalled result holds; the input register keeps taking one more beat.
// Synchronous reset puts the detector in idle and restores register defaults.
module ultrasonic_occupancy_detector
  import uod_pkg::*;
#(
  parameter int ECHO_WIDTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  uod_sample_if.sink    sample,
  uod_result_if.source  result,
  uod_cfg_if.sink       cfg
);

  logic                       in_valid;
  logic [ECHO_WIDTH_BITS-1:0] in_width;
  logic                       in_timeout;
  logic                       out_valid;
  logic [DIST_BITS-1:0]       distance_mcm;
  flow_t                      flow;
  cfg_t                       regs;

  assign flow.result_ready = result.ready;
  assign flow.advance = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || flow.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_width <= sample.echo_width_us;
      in_timeout <= sample.echo_timeout;
    end
  end

  uod_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  uod_distance #(
    .ECHO_WIDTH_BITS (ECHO_WIDTH_BITS)
  ) u_distance (
    .echo_width_us (in_width),
    .echo_timeout  (in_timeout),
    .distance_mcm  (distance_mcm)
  );

  uod_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .flow         (flow),
    .regs         (regs),
    .distance_mcm (distance_mcm),
    .echo_timeout (in_timeout),
    .out_valid    (out_valid),
    .result       (result)
  );

endmodule

/* design/uod_cfg_regs.sv */
`timescale 1ns / 1ps

module uod_cfg_regs
  import uod_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  uod_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window_low <= WINDOW_LOW_RESET;
      regs.window_high <= WINDOW_HIGH_RESET;
      regs.match_tolerance <= MATCH_TOLERANCE_RESET;
      regs.exit_samples <= EXIT_SAMPLES_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WINDOW_LOW:      regs.window_low <= cfg.data;
        REG_WINDOW_HIGH:     regs.window_high <= cfg.data;
        REG_MATCH_TOLERANCE: regs.match_tolerance <= cfg.data;
        REG_EXIT_SAMPLES:    regs.exit_samples <= cfg.data[EXIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/uod_distance.sv */
`timescale 1ns / 1ps

module uod_distance
  import uod_pkg::*;
#(
  parameter int ECHO_WIDTH_BITS = 16
) (
  input  logic [ECHO_WIDTH_BITS-1:0] echo_width_us,
  input  logic                       echo_timeout,
  output logic [DIST_BITS-1:0]       distance_mcm
);

  localparam int PROD_BITS = ECHO_WIDTH_BITS + 5;
  localparam int CALC_BITS = (PROD_BITS > DIST_BITS) ? PROD_BITS : DIST_BITS;

  logic [CALC_BITS-1:0] product;
  logic                 overflow;

  // Times 17 is a shift by four plus the value itself.
  assign product = CALC_BITS'({echo_width_us, 4'b0000}) + CALC_BITS'(echo_width_us);
  assign overflow = product > CALC_BITS'(DIST_MAX);

  always_comb begin
    if (echo_timeout) begin
      distance_mcm = '0;
    end else if (overflow) begin
      distance_mcm = DIST_MAX;
    end else begin
      distance_mcm = product[DIST_BITS-1:0];
    end
  end

endmodule

/* design/uod_tracker.sv */
`timescale 1ns / 1ps

module uod_tracker
  import uod_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  flow_t                flow,
  input  cfg_t                 regs,
  input  logic [DIST_BITS-1:0] distance_mcm,
  input  logic                 echo_timeout,
  output logic                 out_valid,
  uod_result_if.source         result
);

  state_t               state;
  state_t               state_next;
  logic [DIST_BITS-1:0] anchor_mcm;
  logic [DIST_BITS-1:0] anchor_mcm_next;
  logic [EXIT_BITS-1:0] miss_count;
  logic [EXIT_BITS-1:0] miss_count_next;
  logic [EXIT_BITS-1:0] miss_inc;
  logic [DIST_BITS-1:0] diff;
  logic                 in_window;
  logic                 match;
  logic                 arrived;
  logic                 left;
  logic [PHASE_BITS-1:0] phase_code;

  assign in_window = !echo_timeout && (distance_mcm > regs.window_low)
                     && (distance_mcm < regs.window_high);
  assign diff = (distance_mcm >= anchor_mcm) ? distance_mcm - anchor_mcm
                                             : anchor_mcm - distance_mcm;
  assign match = !echo_timeout && (diff <= regs.match_tolerance);
  assign miss_inc = miss_count + 1'b1;

  always_comb begin
    state_next = state;
    anchor_mcm_next = anchor_mcm;
    miss_count_next = miss_count;
    arrived = 1'b0;
    left = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_window) begin
          anchor_mcm_next = distance_mcm;
          state_next = ST_CONFIRM;
        end
      end
      ST_CONFIRM: begin
        if (match) begin
          state_next = ST_PRESENT;
          arrived = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PRESENT: begin
        if (!in_window) begin
          state_next = ST_EXIT;
          miss_count_next = '0;
        end
      end
      ST_EXIT: begin
        if (in_window) begin
          state_next = ST_PRESENT;
          miss_count_next = '0;
        end else if (miss_inc >= regs.exit_samples) begin
          // A zero setting acts like one: the first further miss ends it.
          state_next = ST_IDLE;
          miss_count_next = '0;
          left = 1'b1;
        end else begin
          miss_count_next = miss_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (state_next)
      ST_IDLE:    phase_code = PHASE_IDLE;
      ST_CONFIRM: phase_code = PHASE_CONFIRM;
      ST_PRESENT: phase_code = PHASE_PRESENT;
      ST_EXIT:    phase_code = PHASE_EXIT;
      default:    phase_code = PHASE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      anchor_mcm <= '0;
      miss_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (flow.advance) begin
        state <= state_next;
        anchor_mcm <= anchor_mcm_next;
        miss_count <= miss_count_next;
        out_valid <= 1'b1;
      end else if (flow.result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flow.advance) begin
      result.distance_mcm <= distance_mcm;
      result.car_present <= (state_next == ST_PRESENT) || (state_next == ST_EXIT);
      result.car_arrived <= arrived;
      result.car_left <= left;
      result.phase <= phase_code;
    end
  end

  assign result.valid = out_valid;

endmodule
